// ----- rtl/mexp_pkg.sv -----
package mexp_pkg;

  localparam int EXP_BITS  = 63;
  localparam int MOD_BITS  = 31;
  localparam int BASE_BITS = 32;

  localparam int EXP_CW  = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;
  localparam int MUL_CW  = (MOD_BITS > 1) ? $clog2(MOD_BITS) : 1;
  localparam int BASE_CW = $clog2(BASE_BITS);

  localparam logic [63:0] MOD_RESET_FULL = 64'd1000000007;
  localparam logic [MOD_BITS-1:0] MOD_RESET = MOD_RESET_FULL[MOD_BITS-1:0];

  localparam logic [EXP_CW-1:0]  EXP_LAST  = EXP_CW'(EXP_BITS - 1);
  localparam logic [MUL_CW-1:0]  MUL_LAST  = MUL_CW'(MOD_BITS - 1);
  localparam logic [BASE_CW-1:0] BASE_LAST = BASE_CW'(BASE_BITS - 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RED  = 5'b00010,
    S_SQR  = 5'b00100,
    S_MUL  = 5'b01000,
    S_DONE = 5'b10000
  } mexp_state_t;

endpackage

// ----- rtl/modular_exponentiation.sv -----
// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_stall  in_base, in_exponent
// out_      output     out_valid/out_stall out_power
// cfg_      input      cfg_valid/cfg_ready cfg_modulus
//
// One item at a time. The base is first reduced bit-serially by the modulus, then every
// exponent bit costs one bit-serial modular squaring plus one bit-serial modular
// multiplication when the bit is set. A zero exponent or zero modulus skips the
// reduction and the exponent loop and goes straight to the result.
// Reset restores the modulus to 1000000007. A stalled result is held in the output
// register while the next item is accepted and computed.
module modular_exponentiation
  import mexp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [BASE_BITS-1:0] in_base,
  input  logic [EXP_BITS-1:0] in_exponent,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [MOD_BITS-1:0] out_power,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [MOD_BITS-1:0] cfg_modulus
);

  mexp_state_t state_r, state_nxt;
  logic [MOD_BITS-1:0]  mod_r, mod_nxt;
  logic [BASE_BITS-1:0] base_r, base_nxt;
  logic [EXP_BITS-1:0]  exp_r, exp_nxt;
  logic [MOD_BITS-1:0]  b_r, b_nxt;
  logic [MOD_BITS-1:0]  acc_r, acc_nxt;
  logic [MOD_BITS-1:0]  prod_r, prod_nxt;
  logic [MOD_BITS-1:0]  y_r, y_nxt;
  logic [MUL_CW-1:0]    mcnt_r, mcnt_nxt;
  logic [EXP_CW-1:0]    ecnt_r, ecnt_nxt;
  logic [BASE_CW-1:0]   bcnt_r, bcnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [MOD_BITS-1:0]  out_power_r, out_power_nxt;

  logic                 in_xfer;
  logic [MOD_BITS:0]    mod_ext;
  logic [MOD_BITS:0]    red_sh;
  logic [MOD_BITS-1:0]  red_res;
  logic [MOD_BITS-1:0]  mul_x;
  logic [MOD_BITS:0]    dbl;
  logic [MOD_BITS-1:0]  dbl_red;
  logic [MOD_BITS:0]    sum;
  logic [MOD_BITS-1:0]  mul_res;
  logic                 exp_last;

  assign in_xfer   = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_power = out_power_r;
  assign mod_ext   = {1'b0, mod_r};
  assign exp_last  = (ecnt_r == '0);

  // Base reduction step: shift in one base bit and subtract the modulus once if not below it.
  always_comb begin
    red_sh = {prod_r, base_r[BASE_BITS-1]};
    if (red_sh >= mod_ext) begin
      red_sh = red_sh - mod_ext;
    end
    red_res = red_sh[MOD_BITS-1:0];
  end

  // Interleaved modular multiplication step: double, then add x if the multiplier bit is set.
  always_comb begin
    mul_x = (state_r == S_MUL) ? b_r : acc_r;
    dbl = {prod_r, 1'b0};
    if (dbl >= mod_ext) begin
      dbl = dbl - mod_ext;
    end
    dbl_red = dbl[MOD_BITS-1:0];
    sum = {1'b0, dbl_red} + (y_r[MOD_BITS-1] ? {1'b0, mul_x} : '0);
    if (sum >= mod_ext) begin
      sum = sum - mod_ext;
    end
    mul_res = sum[MOD_BITS-1:0];
  end

  always_comb begin
    state_nxt     = state_r;
    mod_nxt       = mod_r;
    base_nxt      = base_r;
    exp_nxt       = exp_r;
    b_nxt         = b_r;
    acc_nxt       = acc_r;
    prod_nxt      = prod_r;
    y_nxt         = y_r;
    mcnt_nxt      = mcnt_r;
    ecnt_nxt      = ecnt_r;
    bcnt_nxt      = bcnt_r;
    out_valid_nxt = out_valid_r;
    out_power_nxt = out_power_r;

    if (cfg_valid && cfg_ready) begin
      mod_nxt = cfg_modulus;
    end
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          base_nxt = in_base;
          exp_nxt  = in_exponent;
          prod_nxt = '0;
          bcnt_nxt = BASE_LAST;
          ecnt_nxt = EXP_LAST;
          if (in_exponent == '0) begin
            acc_nxt   = MOD_BITS'(1);
            state_nxt = S_DONE;
          end else if (mod_r == '0) begin
            acc_nxt   = '0;
            state_nxt = S_DONE;
          end else begin
            acc_nxt   = (mod_r == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
            state_nxt = S_RED;
          end
        end
      end
      S_RED: begin
        prod_nxt = red_res;
        base_nxt = base_r << 1;
        bcnt_nxt = bcnt_r - 1'b1;
        if (bcnt_r == '0) begin
          b_nxt     = red_res;
          prod_nxt  = '0;
          y_nxt     = acc_r;
          mcnt_nxt  = MUL_LAST;
          state_nxt = S_SQR;
        end
      end
      S_SQR, S_MUL: begin
        prod_nxt = mul_res;
        y_nxt    = y_r << 1;
        mcnt_nxt = mcnt_r - 1'b1;
        if (mcnt_r == '0) begin
          acc_nxt  = mul_res;
          prod_nxt = '0;
          y_nxt    = mul_res;
          mcnt_nxt = MUL_LAST;
          if (state_r == S_SQR && exp_r[EXP_BITS-1]) begin
            state_nxt = S_MUL;
          end else if (exp_last) begin
            state_nxt = S_DONE;
          end else begin
            exp_nxt   = exp_r << 1;
            ecnt_nxt  = ecnt_r - 1'b1;
            state_nxt = S_SQR;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_power_nxt = acc_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mod_r       <= MOD_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mod_r       <= mod_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r      <= base_nxt;
    exp_r       <= exp_nxt;
    b_r         <= b_nxt;
    acc_r       <= acc_nxt;
    prod_r      <= prod_nxt;
    y_r         <= y_nxt;
    mcnt_r      <= mcnt_nxt;
    ecnt_r      <= ecnt_nxt;
    bcnt_r      <= bcnt_nxt;
    out_power_r <= out_power_nxt;
  end

endmodule

// ----- bench/testbench.sv -----
module testbench
  import mexp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int HOLD_LEN    = 12000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [BASE_BITS-1:0] in_base = '0;
  logic [EXP_BITS-1:0]  in_exponent = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [MOD_BITS-1:0]  out_power;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [MOD_BITS-1:0]  cfg_modulus = '0;

  logic [MOD_BITS-1:0] power_queue[$];
  logic [MOD_BITS-1:0] modulus_shadow = MOD_RESET;

  int  cycle_count = 0;
  int  fail_count = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  modulus_writes = 0;
  int  stall_pct = 0;
  int  run_left = 0;
  int  hold_count = 0;
  bit  long_hold = 1'b0;
  bit  stall_level = 1'b0;

  modular_exponentiation DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_base    (in_base),
    .in_exponent(in_exponent),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_power  (out_power),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_modulus(cfg_modulus)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [MOD_BITS-1:0] calc_power(logic [BASE_BITS-1:0] b,
                                                     logic [EXP_BITS-1:0] e,
                                                     logic [MOD_BITS-1:0] m);
    logic [63:0] mm;
    logic [63:0] bb;
    logic [63:0] acc;
    mm = 64'(m);
    if (e == '0) return MOD_BITS'(1);
    if (m == '0) return '0;
    bb = 64'(b) % mm;
    acc = 64'd1 % mm;
    for (int i = EXP_BITS - 1; i >= 0; i--) begin
      acc = (acc * acc) % mm;
      if (e[i]) acc = (acc * bb) % mm;
    end
    return acc[MOD_BITS-1:0];
  endfunction

  // The receiver stalls in runs of random length; a long hold overrides the runs.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (long_hold) begin
      if (hold_count < HOLD_LEN) begin
        out_stall <= 1'b1;
        hold_count = hold_count + 1;
      end else begin
        long_hold = 1'b0;
        hold_count = 0;
        out_stall <= 1'b0;
      end
    end else begin
      if (run_left > 0) begin
        run_left = run_left - 1;
      end else begin
        stall_level = ($urandom_range(0, 99) < stall_pct);
        run_left = $urandom_range(0, 6);
      end
      out_stall <= stall_level;
    end
  end

  always @(posedge clk) begin
    logic [MOD_BITS-1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (power_queue.size() == 0) begin
        $error("power: no result expected, actual %0d", out_power);
        fail_count++;
      end else begin
        want = power_queue.pop_front();
        if (out_power !== want) begin
          $error("power mismatch: expected %0d, actual %0d", want, out_power);
          fail_count++;
        end
      end
    end
  end

  task automatic send_item(input logic [BASE_BITS-1:0] b, input logic [EXP_BITS-1:0] e);
    in_valid <= 1'b1;
    in_base <= b;
    in_exponent <= e;
    do @(posedge clk); while (in_stall);
    power_queue.insert(power_queue.size(), calc_power(b, e, modulus_shadow));
    items_sent++;
  endtask

  task automatic drain_results;
    in_valid <= 1'b0;
    while (power_queue.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_modulus(input logic [MOD_BITS-1:0] m);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_modulus <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    modulus_shadow = m;
    modulus_writes++;
  endtask

  function automatic logic [BASE_BITS-1:0] pick_base();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 20);
      1: return BASE_BITS'(modulus_shadow) + $urandom_range(0, 3) - 2;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [EXP_BITS-1:0] pick_exponent();
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: return EXP_BITS'($urandom_range(0, 64));
      1: return EXP_BITS'(1) << $urandom_range(0, EXP_BITS - 1);
      default: return wide[EXP_BITS-1:0];
    endcase
  endfunction

  task automatic test_reset_modulus;
    stall_pct = 0;
    send_item('0, '0);
    send_item('1, '0);
    send_item('0, EXP_BITS'(5));
    send_item(BASE_BITS'(1), '1);
    send_item('1, EXP_BITS'(1));
    send_item(BASE_BITS'(1000000007), EXP_BITS'(3));
    send_item(BASE_BITS'(3), EXP_BITS'(1) << (EXP_BITS - 1));
    send_item('1, '1);
    drain_results();
  endtask

  task automatic test_degenerate_moduli;
    stall_pct = 30;
    write_modulus(MOD_BITS'(1));
    send_item(BASE_BITS'(5), '0);
    send_item(BASE_BITS'(5), EXP_BITS'(7));
    send_item('1, '1);
    write_modulus('0);
    send_item(BASE_BITS'(9), '0);
    send_item(BASE_BITS'(9), EXP_BITS'(1));
    send_item('0, '1);
    write_modulus(MOD_BITS'(2));
    send_item('1, EXP_BITS'(1));
    send_item(BASE_BITS'(32'hFFFF_FFFE), EXP_BITS'(5));
    drain_results();
  endtask

  task automatic test_max_modulus;
    stall_pct = 50;
    write_modulus('1);
    send_item('1, '1);
    send_item(BASE_BITS'(32'h7FFF_FFFF), EXP_BITS'(2));
    send_item(BASE_BITS'(32'h7FFF_FFFE), EXP_BITS'(2));
    send_item(BASE_BITS'(123456789), EXP_BITS'(1));
    send_item('0, '0);
    drain_results();
  endtask

  // The output register fills, the next item is computed, and the input then stalls.
  task automatic test_output_hold;
    stall_pct = 0;
    write_modulus(MOD_BITS'(97));
    long_hold = 1'b1;
    repeat (4) send_item(pick_base(), pick_exponent());
    drain_results();
  endtask

  task automatic test_random_traffic;
    logic [MOD_BITS-1:0] settings[5];
    int                  gap;
    int                  burst;
    settings[0] = MOD_RESET;
    settings[1] = '1;
    settings[2] = MOD_BITS'($urandom_range(32'h4000_0000, 32'h7FFF_FFFE));
    settings[3] = MOD_BITS'($urandom_range(3, 1000));
    settings[4] = MOD_BITS'($urandom);
    for (int p = 0; p < 5; p++) begin
      write_modulus(settings[p]);
      stall_pct = p * 20;
      for (int n = 0; n < 23; ) begin
        burst = $urandom_range(1, 6);
        for (int k = 0; k < burst && n < 23; k++, n++) send_item(pick_base(), pick_exponent());
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        if ($urandom_range(0, 9) == 0) drain_results();
      end
    end
    drain_results();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_modulus();
    test_degenerate_moduli();
    test_max_modulus();
    test_output_hold();
    test_random_traffic();
    write_modulus(MOD_RESET);
    drain_results();
    repeat (100) @(posedge clk);
    if (power_queue.size() != 0) begin
      $error("power: %0d results never arrived", power_queue.size());
      fail_count++;
    end
    $display("Checked %0d results from %0d items across %0d modulus writes,",
             results_seen, items_sent, modulus_writes);
    $display("including degenerate moduli, full-width fields and a long output hold.");
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/mexp_pkg.sv
rtl/modular_exponentiation.sv
bench/testbench.sv
